/* rtl/clcd_pkg.sv */
// shared constants for the character lcd controller register block
package clcd_pkg;

    // default store sizes
    localparam int DISPLAY_DEPTH_DEF = 80;
    localparam int ROW_LENGTH_DEF    = 40;
    localparam int GLYPH_DEPTH_DEF   = 64;

    // function codes of an input transaction
    localparam logic [1:0] FUNC_INSTR   = 2'd0;
    localparam logic [1:0] FUNC_DATA    = 2'd1;
    localparam logic [1:0] FUNC_DD_READ = 2'd2;
    localparam logic [1:0] FUNC_CG_READ = 2'd3;

    // instruction decode masks and match patterns
    localparam logic [7:0] MASK_FUNC_SET  = 8'he0;
    localparam logic [7:0] OP_FUNC_SET    = 8'h20;
    localparam logic [7:0] MASK_DISP_CTRL = 8'hf8;
    localparam logic [7:0] OP_DISP_CTRL   = 8'h08;
    localparam logic [7:0] OP_CLEAR       = 8'h01;
    localparam logic [7:0] MASK_HOME      = 8'hfe;
    localparam logic [7:0] OP_HOME        = 8'h02;
    localparam logic [7:0] MASK_ENTRY     = 8'hfc;
    localparam logic [7:0] OP_ENTRY       = 8'h04;
    localparam logic [7:0] MASK_CG_ADDR   = 8'hc0;
    localparam logic [7:0] OP_CG_ADDR     = 8'h40;
    localparam logic [7:0] MASK_DD_ADDR   = 8'h80;
    localparam logic [7:0] OP_DD_ADDR     = 8'h80;

    // fill character written by clear
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // controller states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

endpackage

/* rtl/char_lcd_controller_registers.sv */
// character lcd controller register block: instruction decode, display and glyph stores
// an accepted transaction is captured first; its result is then registered in the output register once that can take it
// a new transaction is taken only after the last has left execution; input is stalled until then
// clear display adds a sweep over every display ram entry, writing spaces, with input stalled
// reset (synchronous, active low) zeroes addresses, mode bits and the per-entry valid bits
// an entry not yet written since reset reads as zero; no clearing pass after reset
module char_lcd_controller_registers #(
    parameter int DISPLAY_DEPTH = clcd_pkg::DISPLAY_DEPTH_DEF,
    parameter int ROW_LENGTH    = clcd_pkg::ROW_LENGTH_DEF,
    parameter int GLYPH_DEPTH   = clcd_pkg::GLYPH_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_byte_in,
    input  logic [6:0] i_read_index,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic [6:0] o_address_counter,
    output logic [5:0] o_glyph_address,
    output logic       o_display_on,
    output logic       o_cursor_on,
    output logic       o_blink_on,
    output logic       o_two_line,
    output logic       o_increment_mode,
    output logic       o_ram_select
);
    import clcd_pkg::*;

    // index widths of the two stores
    localparam int AW = $clog2(DISPLAY_DEPTH);
    localparam int GW = $clog2(GLYPH_DEPTH);
    localparam logic [7:0] DD_LIMIT = 8'(DISPLAY_DEPTH);
    localparam logic [6:0] ROW_LIM  = 7'(ROW_LENGTH);
    localparam logic [6:0] CG_LIMIT = 7'(GLYPH_DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(DISPLAY_DEPTH - 1);

    // the two stores
    logic [7:0] r_dd_mem [DISPLAY_DEPTH];
    logic [4:0] r_cg_mem [GLYPH_DEPTH];

    // per-entry valid bits, cleared by reset
    logic [DISPLAY_DEPTH-1:0] r_dd_vld;
    logic [GLYPH_DEPTH-1:0]   r_cg_vld;

    // control
    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [AW-1:0] r_clr_cnt;

    // architectural registers
    logic [6:0] r_dd_addr, n_dd_addr;
    logic [5:0] r_cg_addr, n_cg_addr;
    logic       r_two_line, n_two_line;
    logic       r_disp_on, n_disp_on;
    logic       r_cur_on, n_cur_on;
    logic       r_blink_on, n_blink_on;
    logic       r_inc, n_inc;
    logic       r_ram_sel, n_ram_sel;

    // captured transaction and registered read results
    logic [1:0] r_func;
    logic [7:0] r_byte;
    logic [7:0] r_dd_q;
    logic [4:0] r_cg_q;
    logic       r_dd_hit;
    logic       r_cg_hit;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_data;

    logic in_accept;
    logic out_free;
    logic advance;
    logic start_clear;
    logic rd_dd_ok;
    logic rd_cg_ok;

    // data write decode
    logic       dd_wr;
    logic [6:0] dd_idx;
    logic [5:0] dd_col;
    logic       dd_ok;
    logic       cg_wr;
    logic [7:0] rd_value;

    // memory write port selection
    logic          dd_we;
    logic [AW-1:0] dd_waddr;
    logic [7:0]    dd_wdata;

    assign o_stall   = (r_state != ST_IDLE);
    assign in_accept = i_valid && !o_stall;
    // the result leaves exec only when the output register can take it
    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = (r_state == ST_EXEC) && out_free;

    assign rd_dd_ok = ({1'b0, i_read_index} < DD_LIMIT);
    assign rd_cg_ok = (i_read_index < CG_LIMIT);

    // display ram placement of the current address
    assign dd_col = r_dd_addr[5:0];
    always_comb begin
        if (r_two_line) begin
            dd_ok  = ({1'b0, dd_col} < ROW_LIM);
            dd_idx = r_dd_addr[6] ? ({1'b0, dd_col} + ROW_LIM) : {1'b0, dd_col};
        end else begin
            dd_ok  = 1'b1;
            dd_idx = r_dd_addr;
        end
    end

    assign dd_wr = advance && (r_func == FUNC_DATA) && r_ram_sel && dd_ok
                   && ({1'b0, dd_idx} < DD_LIMIT);
    assign cg_wr = advance && (r_func == FUNC_DATA) && !r_ram_sel
                   && ({1'b0, r_cg_addr} < CG_LIMIT);

    // instruction and data execution
    always_comb begin
        n_dd_addr   = r_dd_addr;
        n_cg_addr   = r_cg_addr;
        n_two_line  = r_two_line;
        n_disp_on   = r_disp_on;
        n_cur_on    = r_cur_on;
        n_blink_on  = r_blink_on;
        n_inc       = r_inc;
        n_ram_sel   = r_ram_sel;
        start_clear = 1'b0;
        rd_value    = 8'd0;
        case (r_func)
            FUNC_INSTR: begin
                if ((r_byte & MASK_FUNC_SET) == OP_FUNC_SET) begin
                    n_two_line = r_byte[3];
                end else if ((r_byte & MASK_DISP_CTRL) == OP_DISP_CTRL) begin
                    n_disp_on  = r_byte[2];
                    n_cur_on   = r_byte[1];
                    n_blink_on = r_byte[0];
                end else if (r_byte == OP_CLEAR) begin
                    n_dd_addr   = 7'd0;
                    n_inc       = 1'b1;
                    start_clear = 1'b1;
                end else if ((r_byte & MASK_HOME) == OP_HOME) begin
                    n_dd_addr = 7'd0;
                end else if ((r_byte & MASK_ENTRY) == OP_ENTRY) begin
                    n_inc = r_byte[1];
                end else if ((r_byte & MASK_CG_ADDR) == OP_CG_ADDR) begin
                    n_cg_addr = r_byte[5:0];
                    n_ram_sel = 1'b0;
                end else if ((r_byte & MASK_DD_ADDR) == OP_DD_ADDR) begin
                    n_dd_addr = r_byte[6:0];
                    n_ram_sel = 1'b1;
                end
            end
            FUNC_DATA: begin
                // address steps even when the write is dropped
                if (r_ram_sel) begin
                    n_dd_addr = r_inc ? (r_dd_addr + 7'd1) : (r_dd_addr - 7'd1);
                end else begin
                    n_cg_addr = r_inc ? (r_cg_addr + 6'd1) : (r_cg_addr - 6'd1);
                end
            end
            FUNC_DD_READ: begin
                rd_value = r_dd_hit ? r_dd_q : 8'd0;
            end
            default: begin
                rd_value = r_cg_hit ? {3'd0, r_cg_q} : 8'd0;
            end
        endcase
    end

    // state sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (advance) begin
                    n_state = start_clear ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (r_clr_cnt == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // display ram write port: data writes or the clear sweep
    always_comb begin
        if (r_state == ST_CLEAR) begin
            dd_we    = 1'b1;
            dd_waddr = r_clr_cnt;
            dd_wdata = CHAR_SPACE;
        end else begin
            dd_we    = dd_wr;
            dd_waddr = dd_idx[AW-1:0];
            dd_wdata = r_byte;
        end
    end

    // display ram
    always_ff @(posedge i_clk) begin
        if (dd_we) begin
            r_dd_mem[dd_waddr] <= dd_wdata;
        end
        if (in_accept) begin
            r_dd_q <= r_dd_mem[i_read_index[AW-1:0]];
        end
    end

    // glyph ram
    always_ff @(posedge i_clk) begin
        if (cg_wr) begin
            r_cg_mem[r_cg_addr[GW-1:0]] <= r_byte[4:0];
        end
        if (in_accept) begin
            r_cg_q <= r_cg_mem[i_read_index[GW-1:0]];
        end
    end

    // control and architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clr_cnt   <= '0;
            r_dd_vld    <= '0;
            r_cg_vld    <= '0;
            r_dd_addr   <= 7'd0;
            r_cg_addr   <= 6'd0;
            r_two_line  <= 1'b0;
            r_disp_on   <= 1'b0;
            r_cur_on    <= 1'b0;
            r_blink_on  <= 1'b0;
            r_inc       <= 1'b0;
            r_ram_sel   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= (r_clr_cnt == CLR_LAST) ? '0 : (r_clr_cnt + AW'(1));
            end
            if (dd_we) begin
                r_dd_vld[dd_waddr] <= 1'b1;
            end
            if (cg_wr) begin
                r_cg_vld[r_cg_addr[GW-1:0]] <= 1'b1;
            end
            if (advance) begin
                r_dd_addr  <= n_dd_addr;
                r_cg_addr  <= n_cg_addr;
                r_two_line <= n_two_line;
                r_disp_on  <= n_disp_on;
                r_cur_on   <= n_cur_on;
                r_blink_on <= n_blink_on;
                r_inc      <= n_inc;
                r_ram_sel  <= n_ram_sel;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func   <= i_func;
            r_byte   <= i_byte_in;
            r_dd_hit <= rd_dd_ok && r_dd_vld[i_read_index[AW-1:0]];
            r_cg_hit <= rd_cg_ok && r_cg_vld[i_read_index[GW-1:0]];
        end
        if (advance) begin
            r_out_data <= rd_value;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_read_data       = r_out_data;
    // status registers only change when a result is loaded, so they stand for it
    assign o_address_counter = r_dd_addr;
    assign o_glyph_address   = r_cg_addr;
    assign o_display_on      = r_disp_on;
    assign o_cursor_on       = r_cur_on;
    assign o_blink_on        = r_blink_on;
    assign o_two_line        = r_two_line;
    assign o_increment_mode  = r_inc;
    assign o_ram_select      = r_ram_sel;

`ifndef SYNTHESIS
    // an accepted transaction always moves to execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_EXEC))
        else $error("accepted transaction did not enter execution");

    // a pending result that is stalled is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !advance || !i_stall)
        else $error("output register overwritten while stalled");

    // the clear sweep ends with every display entry valid
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CLEAR) && (r_clr_cnt == CLR_LAST)) |=>
            ((r_state == ST_IDLE) && (&r_dd_vld)))
        else $error("clear sweep left display entries unwritten");

    // no data write competes with the clear sweep
    a_clear_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!dd_wr && !cg_wr && o_stall))
        else $error("store access during clear sweep");
`endif

endmodule

/* dv/char_lcd_controller_registers_test.sv */
// self-checking testbench for the character lcd controller register block
`timescale 1ns / 100ps

module char_lcd_controller_registers_test;
    import clcd_pkg::*;

    localparam int DISP_N  = DISPLAY_DEPTH_DEF;
    localparam int ROW_N   = ROW_LENGTH_DEF;
    localparam int GLYPH_N = GLYPH_DEPTH_DEF;

    // random transactions per idling phase, four phases in all
    localparam int RANDOM_PER_PHASE = 432;
    // worst case is far below this limit, also on the slow phases
    localparam int CYCLE_LIMIT = 400000;
    // quiet cycles after the last result
    localparam int TAIL_CYCLES = 16;

    // one result transaction, fields in port order
    typedef struct packed {
        logic [7:0] read_data;
        logic [6:0] address_counter;
        logic [5:0] glyph_address;
        logic       display_on;
        logic       cursor_on;
        logic       blink_on;
        logic       two_line;
        logic       increment_mode;
        logic       ram_select;
    } t_lcd_status;

    // one input transaction; fixed rows carry a hand-written expected status
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  byte_in;
        logic [6:0]  read_index;
        logic        fixed;
        t_lcd_status status;
    } t_lcd_cmd;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_func;
    logic [7:0] i_byte_in;
    logic [6:0] i_read_index;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_read_data;
    logic [6:0] o_address_counter;
    logic [5:0] o_glyph_address;
    logic       o_display_on;
    logic       o_cursor_on;
    logic       o_blink_on;
    logic       o_two_line;
    logic       o_increment_mode;
    logic       o_ram_select;

    char_lcd_controller_registers u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_byte_in         (i_byte_in),
        .i_read_index      (i_read_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_read_data       (o_read_data),
        .o_address_counter (o_address_counter),
        .o_glyph_address   (o_glyph_address),
        .o_display_on      (o_display_on),
        .o_cursor_on       (o_cursor_on),
        .o_blink_on        (o_blink_on),
        .o_two_line        (o_two_line),
        .o_increment_mode  (o_increment_mode),
        .o_ram_select      (o_ram_select)
    );

    // 8 ns period
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shadow copy of the controller state
    // ------------------------------------------------------------------
    logic [7:0] disp_mem  [DISP_N];
    logic [4:0] glyph_mem [GLYPH_N];
    logic [6:0] dd_addr;
    logic [5:0] cg_addr;
    // only the mode bits that reach an output are kept
    logic       m_display, m_cursor, m_blink, m_two_line, m_increment, m_ram_sel;

    // expected results in issue order
    t_lcd_status pending_status[$];

    int unsigned idle_pct;
    int unsigned stall_pct;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // applies one access to the shadow state and returns the status it produces
    function automatic t_lcd_status apply_lcd_access(input logic [1:0] f,
                                                     input logic [7:0] b,
                                                     input logic [6:0] ri);
        t_lcd_status s;
        int          idx;
        int          col;
        logic        in_row;
        s = '0;
        case (f)
            FUNC_INSTR: begin
                // decode order matters: first match wins
                if ((b & MASK_FUNC_SET) == OP_FUNC_SET) begin
                    m_two_line = b[3];
                end else if ((b & MASK_DISP_CTRL) == OP_DISP_CTRL) begin
                    m_display = b[2];
                    m_cursor  = b[1];
                    m_blink   = b[0];
                end else if (b == OP_CLEAR) begin
                    dd_addr     = '0;
                    m_increment = 1'b1;
                    for (int i = 0; i < DISP_N; i++) disp_mem[i] = CHAR_SPACE;
                end else if ((b & MASK_HOME) == OP_HOME) begin
                    dd_addr = '0;
                end else if ((b & MASK_ENTRY) == OP_ENTRY) begin
                    m_increment = b[1];
                end else if ((b & MASK_CG_ADDR) == OP_CG_ADDR) begin
                    cg_addr   = b[5:0];
                    m_ram_sel = 1'b0;
                end else if ((b & MASK_DD_ADDR) == OP_DD_ADDR) begin
                    dd_addr   = b[6:0];
                    m_ram_sel = 1'b1;
                end
                // anything else (zero byte, shift commands) is a no-op
            end
            FUNC_DATA: begin
                if (!m_ram_sel) begin
                    if (cg_addr < GLYPH_N) glyph_mem[cg_addr] = b[4:0];
                    cg_addr = m_increment ? cg_addr + 6'd1 : cg_addr - 6'd1;
                end else begin
                    if (m_two_line) begin
                        // bit 6 picks the row, columns past the row length are dropped
                        col    = int'(dd_addr[5:0]);
                        in_row = (col < ROW_N);
                        idx    = dd_addr[6] ? col + ROW_N : col;
                    end else begin
                        idx    = int'(dd_addr);
                        in_row = 1'b1;
                    end
                    if (in_row && idx < DISP_N) disp_mem[idx] = b;
                    // a dropped write still moves the address
                    dd_addr = m_increment ? dd_addr + 7'd1 : dd_addr - 7'd1;
                end
            end
            FUNC_DD_READ: begin
                if (ri < DISP_N) s.read_data = disp_mem[ri];
            end
            default: begin
                if (ri < GLYPH_N) s.read_data = {3'b000, glyph_mem[ri]};
            end
        endcase
        s.address_counter = dd_addr;
        s.glyph_address   = cg_addr;
        s.display_on      = m_display;
        s.cursor_on       = m_cursor;
        s.blink_on        = m_blink;
        s.two_line        = m_two_line;
        s.increment_mode  = m_increment;
        s.ram_select      = m_ram_sel;
        return s;
    endfunction

    // one row of the directed table; flags are {display, cursor, blink, two_line, inc, ram}
    function automatic t_lcd_cmd cmd_entry(input logic [1:0] f, input logic [7:0] b,
                                           input logic [6:0] ri, input logic fixed,
                                           input logic [7:0] rd, input logic [6:0] ac,
                                           input logic [5:0] ga, input logic [5:0] flags);
        t_lcd_cmd c;
        c.func       = f;
        c.byte_in    = b;
        c.read_index = ri;
        c.fixed      = fixed;
        c.status     = {rd, ac, ga, flags};
        return c;
    endfunction

    // random transaction, mostly well-formed commands with random content
    function automatic t_lcd_cmd rand_cmd();
        t_lcd_cmd    c;
        int unsigned pick;
        int unsigned kind;
        c            = '0;
        c.byte_in    = 8'($urandom_range(255));
        c.read_index = 7'($urandom_range(127));
        pick         = $urandom_range(99);
        if (pick < 40) begin
            c.func = FUNC_DATA;
        end else if (pick < 70) begin
            c.func = FUNC_INSTR;
            kind   = $urandom_range(99);
            if (kind < 2) begin
                // clear is slow, keep it rare
                c.byte_in = OP_CLEAR;
            end else if (kind < 6) begin
                c.byte_in = OP_HOME | 8'($urandom_range(1));
            end else if (kind < 18) begin
                c.byte_in = OP_FUNC_SET | 8'($urandom_range(31));
            end else if (kind < 30) begin
                c.byte_in = OP_DISP_CTRL | 8'($urandom_range(7));
            end else if (kind < 42) begin
                c.byte_in = OP_ENTRY | 8'($urandom_range(3));
            end else if (kind < 60) begin
                c.byte_in = OP_CG_ADDR | 8'($urandom_range(63));
            end else if (kind < 96) begin
                // mostly land on a real column, sometimes past the row end
                c.byte_in = OP_DD_ADDR | 8'($urandom_range(1) << 6);
                if ($urandom_range(3) != 0) c.byte_in = c.byte_in | 8'($urandom_range(43));
                else c.byte_in = c.byte_in | 8'($urandom_range(63));
            end else begin
                // unused codes: zero byte and shift commands
                c.byte_in = $urandom_range(1) ? 8'h10 | 8'($urandom_range(15)) : 8'h00;
            end
        end else if (pick < 85) begin
            c.func = FUNC_DD_READ;
            if ($urandom_range(9) != 0) c.read_index = 7'($urandom_range(DISP_N - 1));
        end else begin
            c.func = FUNC_CG_READ;
            if ($urandom_range(9) != 0) c.read_index = 7'($urandom_range(GLYPH_N - 1));
        end
        return c;
    endfunction

    // drives one transaction, waits for its acceptance, then records the expected status
    task automatic issue_cmd(input t_lcd_cmd c);
        t_lcd_status predicted;
        // random idle cycles with junk on the payload
        while ($urandom_range(99) < idle_pct) begin
            i_valid      <= 1'b0;
            i_func       <= 2'($urandom_range(3));
            i_byte_in    <= 8'($urandom_range(255));
            i_read_index <= 7'($urandom_range(127));
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= c.func;
        i_byte_in    <= c.byte_in;
        i_read_index <= c.read_index;
        // stall is settled by the falling edge, the next rising edge takes the transaction
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        predicted = apply_lcd_access(c.func, c.byte_in, c.read_index);
        pending_status.push_back(c.fixed ? c.status : predicted);
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, checked on the falling edge before the
    // rising edge that takes the transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(negedge i_clk) begin : result_check
        t_lcd_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_status.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatch_count++;
            end else begin
                want = pending_status.pop_front();
                check_field("read_data", want.read_data, o_read_data);
                check_field("address_counter", 8'(want.address_counter), 8'(o_address_counter));
                check_field("glyph_address", 8'(want.glyph_address), 8'(o_glyph_address));
                check_field("display_on", 8'(want.display_on), 8'(o_display_on));
                check_field("cursor_on", 8'(want.cursor_on), 8'(o_cursor_on));
                check_field("blink_on", 8'(want.blink_on), 8'(o_blink_on));
                check_field("two_line", 8'(want.two_line), 8'(o_two_line));
                check_field("increment_mode", 8'(want.increment_mode), 8'(o_increment_mode));
                check_field("ram_select", 8'(want.ram_select), 8'(o_ram_select));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL char_lcd_controller_registers");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_lcd_cmd    plan[$];
        int unsigned phase_idle[4];
        int unsigned phase_stall[4];
        // phases: no idling, sender idle, receiver stall, light idling on both
        phase_idle  = '{0, 84, 0, 6};
        phase_stall = '{0, 0, 84, 6};

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_func         = FUNC_INSTR;
        i_byte_in      = '0;
        i_read_index   = '0;
        idle_pct       = 0;
        stall_pct      = 0;

        // shadow state matches the block after reset
        for (int i = 0; i < DISP_N; i++) disp_mem[i] = '0;
        for (int i = 0; i < GLYPH_N; i++) glyph_mem[i] = '0;
        dd_addr     = '0;
        cg_addr     = '0;
        m_display   = 1'b0;
        m_cursor    = 1'b0;
        m_blink     = 1'b0;
        m_two_line  = 1'b0;
        m_increment = 1'b0;
        m_ram_sel   = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: func, byte, index, fixed, read_data, address, glyph address, flags
        // reads right after reset see all zero, in range and past the glyph store
        plan.push_back(cmd_entry(FUNC_DD_READ, 8'h00, 7'd0,   1, 8'h00, 7'h00, 6'h00, 6'b000000));
        plan.push_back(cmd_entry(FUNC_CG_READ, 8'h00, 7'd127, 1, 8'h00, 7'h00, 6'h00, 6'b000000));
        // every mode bit set: two-line, display/cursor/blink, increment, display ram at 0x7f
        plan.push_back(cmd_entry(FUNC_INSTR, 8'h3f, 7'd0, 1, 8'h00, 7'h00, 6'h00, 6'b000100));
        plan.push_back(cmd_entry(FUNC_INSTR, 8'h0f, 7'd0, 1, 8'h00, 7'h00, 6'h00, 6'b111100));
        plan.push_back(cmd_entry(FUNC_INSTR, 8'h07, 7'd0, 1, 8'h00, 7'h00, 6'h00, 6'b111110));
        plan.push_back(cmd_entry(FUNC_INSTR, 8'hff, 7'd0, 1, 8'h00, 7'h7f, 6'h00, 6'b111111));
        // column past the row end is dropped and the address wraps to zero
        plan.push_back(cmd_entry(FUNC_DATA,  8'hff, 7'd0, 1, 8'h00, 7'h00, 6'h00, 6'b111111));
        // from here on the shadow state supplies the expectation
        plan.push_back(cmd_entry(FUNC_DATA,    8'h00, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_INSTR,   8'hc0, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_DATA,    8'ha5, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_DD_READ, 8'h00, 7'd40,  0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h04, 7'd0,   0, '0, '0, '0, '0));
        // glyph ram at its top entry, decrementing
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h7f, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_DATA,    8'hff, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_CG_READ, 8'h00, 7'd63,  0, '0, '0, '0, '0));
        // one-line: decrement wraps from 0 to 0x7f, then a write past the store is dropped
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h20, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h80, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_DATA,    8'h5a, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_DATA,    8'h3c, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_DD_READ, 8'h00, 7'd127, 0, '0, '0, '0, '0));
        // unused codes, home, clear
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h00, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h10, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h1f, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h03, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h01, 7'd0,   0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_DD_READ, 8'h00, 7'd79,  0, '0, '0, '0, '0));
        plan.push_back(cmd_entry(FUNC_INSTR,   8'h08, 7'd0,   0, '0, '0, '0, '0));

        foreach (plan[k]) issue_cmd(plan[k]);
        wait_drained();

        // random part, one idling profile per phase, drained between phases
        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (RANDOM_PER_PHASE) issue_cmd(rand_cmd());
            wait_drained();
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_status.size() == 0) begin
            $display("PASS char_lcd_controller_registers");
        end else begin
            $display("FAIL char_lcd_controller_registers");
        end
        $finish;
    end

endmodule
